### design/gds_pkg.sv
package gds_pkg;

  // Field and register widths
  localparam int PIX_W        = 8;
  localparam int SUM_W        = 9;
  localparam int SRC_WIDTH_W  = 13;
  localparam int SRC_HEIGHT_W = 16;
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 16;

  // Defaults
  localparam int MAX_WIDTH_DEF = 4096;
  localparam logic [SRC_WIDTH_W-1:0]  SRC_WIDTH_RST  = SRC_WIDTH_W'(640);
  localparam logic [SRC_HEIGHT_W-1:0] SRC_HEIGHT_RST = SRC_HEIGHT_W'(480);

  // Rounding constant of the 2x2 average
  localparam logic [1:0] ROUND_QUAD = 2'd2;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SRC_WIDTH  = 1'b0,
    REG_SRC_HEIGHT = 1'b1
  } cfg_reg_t;

  // Line store access request
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } line_req_t;

endpackage

### design/gds_pix_in_if.sv
interface gds_pix_in_if;
  logic                      valid;
  logic                      ready;
  logic [gds_pkg::PIX_W-1:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink (input valid, input pixel, output ready);
endinterface

### design/gds_pix_out_if.sv
interface gds_pix_out_if;
  logic                      valid;
  logic                      ready;
  logic [gds_pkg::PIX_W-1:0] out_pixel;
  logic                      end_of_row;
  logic                      end_of_frame;

  modport source (output valid, output out_pixel, output end_of_row, output end_of_frame,
                  input ready);
  modport sink (input valid, input out_pixel, input end_of_row, input end_of_frame,
                output ready);
endinterface

### design/gds_line_store.sv
module gds_line_store #(
  parameter int DEPTH = gds_pkg::MAX_WIDTH_DEF / 2,
  parameter int IDX_W = 11
) (
  input  logic                      clk,
  input  gds_pkg::line_req_t        req,
  input  logic [IDX_W-1:0]          idx,
  input  logic [gds_pkg::SUM_W-1:0] wdata,
  output logic [gds_pkg::SUM_W-1:0] rdata
);

  logic [gds_pkg::SUM_W-1:0] mem [DEPTH];
  logic [gds_pkg::SUM_W-1:0] rdata_r;

  // Store top-row pair sums
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[idx] <= wdata;
    end
  end

  // Fetch the pair sum for the bottom row; the read data is registered
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rdata_r <= mem[idx];
    end
  end

  assign rdata = rdata_r;

endmodule

### design/gray_downscale_2x2_average.sv
// Path: a source pixel that completes a result is registered in the averaging stage, with
//   the line store read registered alongside it, and the result then moves to the output register.
// Throughput: one source pixel per cycle while the output accepts results; each pixel uses the single line store port
//   at most once.
// Reset: counters cleared, src_width 640, src_height 480, held pixel zero;
//   the line store is not cleared, every entry is written before it is read.
module gray_downscale_2x2_average #(
  parameter int MAX_WIDTH = gds_pkg::MAX_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  gds_pix_in_if.sink                     in_pix,
  gds_pix_out_if.source                  out_pix,
  input  logic                           cfg_we,
  input  logic [gds_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gds_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int LINE_DEPTH = MAX_WIDTH / 2;
  localparam int IDX_W      = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam int COL_W      = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
  localparam int CMP_W      = ($clog2(MAX_WIDTH) + 1 > gds_pkg::SRC_WIDTH_W) ?
                              $clog2(MAX_WIDTH) + 1 : gds_pkg::SRC_WIDTH_W;
  localparam int ROW_W      = gds_pkg::SRC_HEIGHT_W;
  localparam int PW         = gds_pkg::PIX_W;
  localparam int SW         = gds_pkg::SUM_W;

  // Configuration and counters
  logic [gds_pkg::SRC_WIDTH_W-1:0]  src_width_r;
  logic [gds_pkg::SRC_HEIGHT_W-1:0] src_height_r;
  logic [COL_W-1:0]                 col_r, col_nxt;
  logic [ROW_W-1:0]                 row_r, row_nxt;
  logic [PW-1:0]                    held_r;

  // Averaging stage
  logic          s1_v_r;
  logic          s1_use_top_r;
  logic          s1_quad_r;
  logic [SW-1:0] s1_sum_r;
  logic          s1_eor_r;
  logic          s1_eof_r;

  // Output register
  logic          out_v_r;
  logic [PW-1:0] out_pix_r;
  logic          out_eor_r;
  logic          out_eof_r;

  logic                 accept;
  logic                 s1_move;
  logic [CMP_W-1:0]     eff_w;
  logic [ROW_W:0]       eff_h;
  logic                 last_col, last_row, col_odd, row_odd;
  logic                 hold_left, top_row, bot_row;
  logic [SW-1:0]        pair_sum;
  logic [IDX_W-1:0]     line_idx;
  logic [SW-1:0]        line_wdata;
  logic [SW-1:0]        line_rdata;
  gds_pkg::line_req_t   line_req;
  logic [SW+1:0]        quad_sum;
  logic [SW:0]          pair_top;
  logic [PW-1:0]        s1_val;

  // Effective image size
  always_comb begin
    if (src_width_r == '0) begin
      eff_w = CMP_W'(1);
    end else if (CMP_W'(src_width_r) > CMP_W'(MAX_WIDTH)) begin
      eff_w = CMP_W'(MAX_WIDTH);
    end else begin
      eff_w = CMP_W'(src_width_r);
    end
  end

  assign eff_h = (src_height_r == '0) ? (ROW_W+1)'(1) : {1'b0, src_height_r};

  // Classify the current pixel
  assign last_col = (CMP_W'(col_r) + CMP_W'(1)) >= eff_w;
  assign last_row = ({1'b0, row_r} + (ROW_W+1)'(1)) >= eff_h;
  assign col_odd  = col_r[0];
  assign row_odd  = row_r[0];
  assign hold_left = !col_odd && !last_col;
  assign top_row   = !hold_left && !row_odd && !last_row;
  assign bot_row   = !hold_left && row_odd;
  assign pair_sum  = SW'(held_r) + SW'(in_pix.pixel);
  assign line_idx  = IDX_W'(col_r >> 1);

  // Handshake: the averaging stage drains into the output register
  assign s1_move     = s1_v_r && (!out_v_r || out_pix.ready);
  assign in_pix.ready = !s1_v_r || s1_move;
  assign accept      = in_pix.valid && in_pix.ready;

  // Line store access
  assign line_req.wr_en = accept && top_row;
  assign line_req.rd_en = accept && bot_row;
  assign line_wdata     = col_odd ? pair_sum : SW'(in_pix.pixel);

  gds_line_store #(
    .DEPTH (LINE_DEPTH),
    .IDX_W (IDX_W)
  ) u_line_store (
    .clk   (clk),
    .req   (line_req),
    .idx   (line_idx),
    .wdata (line_wdata),
    .rdata (line_rdata)
  );

  // Advance counters
  always_comb begin
    col_nxt = col_r + COL_W'(1);
    row_nxt = row_r;
    if (last_col) begin
      col_nxt = '0;
      row_nxt = last_row ? '0 : row_r + ROW_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_width_r  <= gds_pkg::SRC_WIDTH_RST;
      src_height_r <= gds_pkg::SRC_HEIGHT_RST;
      col_r        <= '0;
      row_r        <= '0;
      held_r       <= '0;
    end else if (cfg_we) begin
      // Restart the frame on any register write
      case (gds_pkg::cfg_reg_t'(cfg_index))
        gds_pkg::REG_SRC_WIDTH:  src_width_r  <= cfg_data[gds_pkg::SRC_WIDTH_W-1:0];
        gds_pkg::REG_SRC_HEIGHT: src_height_r <= cfg_data[gds_pkg::SRC_HEIGHT_W-1:0];
        default: ;
      endcase
      col_r <= '0;
      row_r <= '0;
    end else if (accept) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      if (hold_left) begin
        held_r <= in_pix.pixel;
      end
    end
  end

  // Load the averaging stage with result-producing pixels
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (accept) begin
      s1_v_r <= !hold_left && !top_row;
    end else if (s1_move) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_use_top_r <= row_odd;
      s1_quad_r    <= col_odd;
      s1_eor_r     <= last_col;
      s1_eof_r     <= last_col && last_row;
      if (row_odd) begin
        s1_sum_r <= col_odd ? pair_sum : SW'(in_pix.pixel);
      end else begin
        // Lone last row: finish the value here
        s1_sum_r <= col_odd ? SW'(pair_sum[SW-1:1] + (SW-1)'(pair_sum[0]))
                            : SW'(in_pix.pixel);
      end
    end
  end

  // Combine with the top-row pair sum
  assign quad_sum = (SW+2)'(line_rdata) + (SW+2)'(s1_sum_r) + (SW+2)'(gds_pkg::ROUND_QUAD);
  assign pair_top = (SW+1)'(line_rdata) + (SW+1)'(s1_sum_r) + (SW+1)'(1);

  always_comb begin
    if (!s1_use_top_r) begin
      s1_val = s1_sum_r[PW-1:0];
    end else if (s1_quad_r) begin
      s1_val = quad_sum[PW+1:2];
    end else begin
      s1_val = pair_top[PW:1];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (s1_move) begin
      out_v_r <= 1'b1;
    end else if (out_pix.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_pix_r <= s1_val;
      out_eor_r <= s1_eor_r;
      out_eof_r <= s1_eof_r;
    end
  end

  assign out_pix.valid        = out_v_r;
  assign out_pix.out_pixel    = out_pix_r;
  assign out_pix.end_of_row   = out_eor_r;
  assign out_pix.end_of_frame = out_eof_r;

  // Checks
  a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    CMP_W'(col_r) < eff_w)
    else $error("column counter beyond image width");

  a_one_access: assert property (@(posedge clk) disable iff (!rst_n)
    !(line_req.wr_en && line_req.rd_en))
    else $error("line store read and written in one cycle");

  a_s1_kept: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && !s1_move |=> s1_v_r)
    else $error("averaging stage lost a pending result");

  a_eof_eor: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_eof_r |-> out_eor_r)
    else $error("end of frame without end of row");

  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_v_r |-> in_pix.ready)
    else $error("input stalled with empty averaging stage");

endmodule
